/* rtl/core/lpps_pkg.sv */
// shared types and constants for the limited pair permutation select block
package lpps_pkg;

    localparam int NUM_PAIRS      = 4;
    localparam int COUNT_BITS_DEF = 24;

    // reach is kept as reach+1: 0 means no slot reachable, 1..4 means slot 0..3
    localparam logic [2:0] REACH_NONE  = 3'd0;
    // running best reach at the start of a slot scan (slot 5 in plain terms)
    localparam logic [2:0] REACH_START = 3'd6;

    // control fields that travel down the selection pipeline
    typedef struct packed {
        logic [NUM_PAIRS-1:0][2:0] reach;
        logic [NUM_PAIRS-1:0]      placed;
        logic [NUM_PAIRS-1:0][1:0] slot;
        logic                      found;
    } sel_t;

endpackage

/* rtl/core/limited_pair_permutation_select.sv */
// top level of the limited pair permutation select pipeline
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | count_a0..3, count_b0..3, limit0..3
//  output   | out_valid / out_stall| slot0_pair..slot3_pair, found
//
// five register stages: totals and reach, then one stage per slot
// one item per cycle sustained while out_stall is low
// each slot stage holds one chained (COUNT_BITS+1)-bit compare scan over the four pairs
// reset clears the stage valid bits only; payload registers are not reset
// a stall holds the output item; bubbles upstream still close up behind it
module limited_pair_permutation_select
    import lpps_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COUNT_BITS-1:0] count_a0,
    input  logic [COUNT_BITS-1:0] count_a1,
    input  logic [COUNT_BITS-1:0] count_a2,
    input  logic [COUNT_BITS-1:0] count_a3,
    input  logic [COUNT_BITS-1:0] count_b0,
    input  logic [COUNT_BITS-1:0] count_b1,
    input  logic [COUNT_BITS-1:0] count_b2,
    input  logic [COUNT_BITS-1:0] count_b3,
    input  logic [COUNT_BITS:0]   limit0,
    input  logic [COUNT_BITS:0]   limit1,
    input  logic [COUNT_BITS:0]   limit2,
    input  logic [COUNT_BITS:0]   limit3,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            slot0_pair,
    output logic [1:0]            slot1_pair,
    output logic [1:0]            slot2_pair,
    output logic [1:0]            slot3_pair,
    output logic                  found
);

    localparam int NSTG = NUM_PAIRS + 1;

    logic [NUM_PAIRS-1:0][COUNT_BITS-1:0] cnt_a;
    logic [NUM_PAIRS-1:0][COUNT_BITS-1:0] cnt_b;
    logic [NUM_PAIRS-1:0][COUNT_BITS:0]   lim;

    logic [NSTG-1:0]                      stg_valid;
    logic [NSTG:0]                        stg_ready;
    sel_t                                 stg_sel [NSTG];
    logic [NUM_PAIRS-1:0][COUNT_BITS:0]   stg_tot [NSTG];

    assign cnt_a = {count_a3, count_a2, count_a1, count_a0};
    assign cnt_b = {count_b3, count_b2, count_b1, count_b0};
    assign lim   = {limit3, limit2, limit1, limit0};

    // ready chain from the output back to the input
    assign stg_ready[NSTG] = !out_stall;
    assign in_stall        = !stg_ready[0];

    // totals and reach
    lpps_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .ready_up  (stg_ready[0]),
        .cnt_a     (cnt_a),
        .cnt_b     (cnt_b),
        .lim       (lim),
        .valid_out (stg_valid[0]),
        .ready_dn  (stg_ready[1]),
        .sel_out   (stg_sel[0]),
        .tot_out   (stg_tot[0])
    );

    // one selection stage per slot
    for (genvar s = 0; s < NUM_PAIRS; s++)
    begin : g_slot
        lpps_slot #(
            .COUNT_BITS (COUNT_BITS),
            .SLOT       (s)
        ) u_slot (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stg_valid[s]),
            .ready_up  (stg_ready[s+1]),
            .sel_in    (stg_sel[s]),
            .tot_in    (stg_tot[s]),
            .valid_out (stg_valid[s+1]),
            .ready_dn  (stg_ready[s+2]),
            .sel_out   (stg_sel[s+1]),
            .tot_out   (stg_tot[s+1])
        );
    end

    // result ports
    assign out_valid  = stg_valid[NSTG-1];
    assign slot0_pair = stg_sel[NSTG-1].slot[0];
    assign slot1_pair = stg_sel[NSTG-1].slot[1];
    assign slot2_pair = stg_sel[NSTG-1].slot[2];
    assign slot3_pair = stg_sel[NSTG-1].slot[3];
    assign found      = stg_sel[NSTG-1].found;

`ifndef SYNTHESIS
    // a full result is a permutation of the four pairs
    a_found_perm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (stg_sel[NSTG-1].placed == '1))
        else $error("found result does not place every pair");

    a_found_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (slot0_pair != slot1_pair && slot0_pair != slot2_pair
            && slot0_pair != slot3_pair && slot1_pair != slot2_pair
            && slot1_pair != slot3_pair && slot2_pair != slot3_pair))
        else $error("found result repeats a pair");

    // a failed search never fills the last slot
    a_fail_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (slot3_pair == 2'd0))
        else $error("failed result has a last slot");

    // an empty output stage means the whole pipeline can take an item
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output stage");
`endif

endmodule

/* rtl/core/lpps_front.sv */
// first pipeline stage: pair totals and per-pair reach from the limits
module lpps_front
    import lpps_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  valid_in,
    output logic                                  ready_up,
    input  logic [NUM_PAIRS-1:0][COUNT_BITS-1:0]  cnt_a,
    input  logic [NUM_PAIRS-1:0][COUNT_BITS-1:0]  cnt_b,
    input  logic [NUM_PAIRS-1:0][COUNT_BITS:0]    lim,
    output logic                                  valid_out,
    input  logic                                  ready_dn,
    output sel_t                                  sel_out,
    output logic [NUM_PAIRS-1:0][COUNT_BITS:0]    tot_out
);

    logic                               valid_reg;
    sel_t                               sel_reg;
    sel_t                               sel_next;
    logic [NUM_PAIRS-1:0][COUNT_BITS:0] tot_reg;
    logic [NUM_PAIRS-1:0][COUNT_BITS:0] tot_next;
    logic [NUM_PAIRS-1:0][NUM_PAIRS-1:0] pass;

    // stage takes an item when empty or when its item moves on
    assign ready_up = !valid_reg || ready_dn;

    // per-limit pass bits and totals, one bit wider than the counts
    always_comb
    begin
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            tot_next[p] = {1'b0, cnt_a[p]} + {1'b0, cnt_b[p]};
            for (int s = 0; s < NUM_PAIRS; s++)
            begin
                pass[p][s] = ({1'b0, cnt_a[p]} < lim[s]) && ({1'b0, cnt_b[p]} < lim[s]);
            end
        end
    end

    // reach is the number of leading limits passed
    always_comb
    begin
        sel_next        = '0;
        sel_next.found  = 1'b1;
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            if (!pass[p][0])
                sel_next.reach[p] = REACH_NONE;
            else if (!pass[p][1])
                sel_next.reach[p] = 3'd1;
            else if (!pass[p][2])
                sel_next.reach[p] = 3'd2;
            else if (!pass[p][3])
                sel_next.reach[p] = 3'd3;
            else
                sel_next.reach[p] = 3'd4;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_up)
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            sel_reg <= sel_next;
            tot_reg <= tot_next;
        end
    end

    assign valid_out = valid_reg;
    assign sel_out   = sel_reg;
    assign tot_out   = tot_reg;

endmodule

/* rtl/core/lpps_slot.sv */
// one selection stage: picks the pair for a single slot
module lpps_slot
    import lpps_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int SLOT       = 0
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    output logic                                ready_up,
    input  sel_t                                sel_in,
    input  logic [NUM_PAIRS-1:0][COUNT_BITS:0]  tot_in,
    output logic                                valid_out,
    input  logic                                ready_dn,
    output sel_t                                sel_out,
    output logic [NUM_PAIRS-1:0][COUNT_BITS:0]  tot_out
);

    localparam logic [2:0] SLOT_REACH = 3'(SLOT + 1);

    logic                               valid_reg;
    sel_t                               sel_reg;
    sel_t                               sel_next;
    logic [NUM_PAIRS-1:0][COUNT_BITS:0] tot_reg;
    logic [COUNT_BITS:0]                best_tot;
    logic [2:0]                         best_reach;
    logic [1:0]                         best_idx;
    logic                               best_hit;

    assign ready_up = !valid_reg || ready_dn;

    // running-best scan over the pairs, later pair wins a tie
    always_comb
    begin
        best_tot   = '0;
        best_reach = REACH_START;
        best_idx   = '0;
        best_hit   = 1'b0;
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            if (!sel_in.placed[p] && (sel_in.reach[p] >= SLOT_REACH)
                && (sel_in.reach[p] <= best_reach) && (tot_in[p] >= best_tot))
            begin
                best_tot   = tot_in[p];
                best_reach = sel_in.reach[p];
                best_idx   = 2'(p);
                best_hit   = 1'b1;
            end
        end
    end

    // place the winner, or stop filling once a slot fails
    always_comb
    begin
        sel_next = sel_in;
        if (sel_in.found)
        begin
            if (best_hit)
            begin
                sel_next.slot[SLOT]       = best_idx;
                sel_next.placed[best_idx] = 1'b1;
            end
            else
            begin
                sel_next.found = 1'b0;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_up)
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            sel_reg <= sel_next;
            tot_reg <= tot_in;
        end
    end

    assign valid_out = valid_reg;
    assign sel_out   = sel_reg;
    assign tot_out   = tot_reg;

endmodule
